// File: rtl/netstring_header_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Netstring header deframer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NETSTRING_HEADER_DEFRAMER_UNIT_MACROS_SVH
`define NETSTRING_HEADER_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ndf_pkg.sv
// ----------------------------------------------------------------------------
// Netstring header deframer package
// Shared types, character codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package ndf_pkg;

    localparam int MAX_DIGITS_DEF   = 9;
    localparam int LENGTH_WIDTH_DEF = 16;

    localparam int BYTE_WIDTH   = 8;
    localparam int CFG_WIDTH    = 16;
    localparam int STATUS_WIDTH = 3;
    localparam int HDR_LEN_WIDTH = 16;

    localparam logic [CFG_WIDTH-1:0] CFG_MAX_LENGTH_RST = CFG_WIDTH'(10 * 1024 - 1);

    localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_WIDTH-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_WIDTH-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam int DECIMAL_BASE = 10;

    localparam logic [STATUS_WIDTH-1:0] ST_BUSY     = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_DONE     = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_BADCHAR  = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_TOOBIG   = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_NOCOMMA  = 3'd4;

    typedef enum logic [6:0] {
        PH_DIGITS  = 7'b0000001,
        PH_CONTENT = 7'b0000010,
        PH_COMMA   = 7'b0000100,
        PH_DONE    = 7'b0001000,
        PH_BADCHAR = 7'b0010000,
        PH_TOOBIG  = 7'b0100000,
        PH_NOCOMMA = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] in_byte;
        logic                  restart;
    } t_ndf_item;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0]    data_byte;
        logic                     content_valid;
        logic                     in_value;
        logic                     end_of_string;
        logic [STATUS_WIDTH-1:0]  status;
        logic [HDR_LEN_WIDTH-1:0] header_length;
    } t_ndf_result;

    // Handshake status between the input stage and the result stage.
    typedef struct packed {
        logic fire;
    } t_ndf_ctrl;

endpackage

// File: rtl/ndf_in_stage.sv
// ----------------------------------------------------------------------------
// Netstring header deframer input stage
// Holds one accepted request until the parse step can take it.
// ----------------------------------------------------------------------------
module ndf_in_stage import ndf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_ndf_item i_item,
    input  logic      i_slot_free,
    output t_ndf_ctrl o_ctrl,
    output t_ndf_item o_item
);

    logic      r_valid;
    t_ndf_item r_item;
    logic      fire;

    assign fire    = r_valid & i_slot_free;
    assign o_ready = ~r_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_ctrl.fire  = fire;
    assign o_item       = r_item;

endmodule

// File: rtl/ndf_parse.sv
// ----------------------------------------------------------------------------
// Netstring header deframer parse step
// Holds the parser state and the length limit, and works out one result
// for each byte in a single pass.
// ----------------------------------------------------------------------------
module ndf_parse import ndf_pkg::*; #(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data,
    input  t_ndf_ctrl            i_ctrl,
    input  t_ndf_item            i_item,
    output t_ndf_result          o_result
);

    localparam int AW = LENGTH_WIDTH + 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int XW = (AW > CFG_WIDTH + 1) ? AW : CFG_WIDTH + 1;

    logic [CFG_WIDTH-1:0]    r_max_length;
    t_phase                  r_phase;
    logic [CW-1:0]           r_digit_count;
    logic [AW-1:0]           r_accum;
    logic [LENGTH_WIDTH-1:0] r_remaining;
    logic                    r_value_side;

    t_phase                  n_phase;
    logic [CW-1:0]           n_digit_count;
    logic [AW-1:0]           n_accum;
    logic [LENGTH_WIDTH-1:0] n_remaining;
    logic                    n_value_side;

    t_phase                  cur_phase;
    logic [CW-1:0]           cur_digit_count;
    logic [AW-1:0]           cur_accum;
    logic [LENGTH_WIDTH-1:0] cur_remaining;
    logic                    cur_value_side;

    logic [BYTE_WIDTH-1:0]   c;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [AW+3:0]           times_ten;
    logic [XW-1:0]           accum_x;
    logic                    too_big;
    logic [LENGTH_WIDTH-1:0] rem_dec;

    // A restart clears the state before this byte is looked at.
    always_comb begin
        if (i_item.restart) begin
            cur_phase       = PH_DIGITS;
            cur_digit_count = '0;
            cur_accum       = '0;
            cur_remaining   = '0;
            cur_value_side  = 1'b0;
        end else begin
            cur_phase       = r_phase;
            cur_digit_count = r_digit_count;
            cur_accum       = r_accum;
            cur_remaining   = r_remaining;
            cur_value_side  = r_value_side;
        end
    end

    assign c        = i_item.in_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);
    assign times_ten = ((AW+4)'(cur_accum) << 3) + ((AW+4)'(cur_accum) << 1)
                     + (AW+4)'(digit);
    assign accum_x  = XW'(cur_accum);
    // Beyond the limit register or beyond what the length field can hold.
    assign too_big  = (accum_x > XW'(r_max_length)) || cur_accum[AW-1];
    assign rem_dec  = (cur_remaining != '0) ? cur_remaining - 1'b1 : '0;

    always_comb begin
        n_phase       = cur_phase;
        n_digit_count = cur_digit_count;
        n_accum       = cur_accum;
        n_remaining   = cur_remaining;
        n_value_side  = cur_value_side;
        o_result      = '0;
        case (cur_phase)
            PH_DIGITS: begin
                if (is_digit) begin
                    if (cur_digit_count >= CW'(MAX_DIGITS)) begin
                        n_phase = PH_BADCHAR;
                    end else begin
                        // The accumulator sticks at all ones once it overflows.
                        n_accum       = (|times_ten[AW+3:AW]) ? '1 : times_ten[AW-1:0];
                        n_digit_count = cur_digit_count + 1'b1;
                    end
                end else if (c == CH_COLON) begin
                    if (too_big) begin
                        n_phase = PH_TOOBIG;
                    end else if (cur_accum == '0) begin
                        n_phase = PH_COMMA;
                    end else begin
                        n_remaining = cur_accum[LENGTH_WIDTH-1:0];
                        n_phase     = PH_CONTENT;
                    end
                end else begin
                    n_phase = PH_BADCHAR;
                end
            end
            PH_CONTENT: begin
                o_result.data_byte     = c;
                o_result.content_valid = 1'b1;
                o_result.in_value      = cur_value_side;
                o_result.end_of_string = (c == CH_NUL);
                if (c == CH_NUL) begin
                    n_value_side = ~cur_value_side;
                end
                n_remaining = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_COMMA;
                end
            end
            PH_COMMA: begin
                n_phase = (c == CH_COMMA) ? PH_DONE : PH_NOCOMMA;
            end
            default: begin
            end
        endcase

        case (n_phase)
            PH_DIGITS, PH_CONTENT, PH_COMMA: o_result.status = ST_BUSY;
            PH_DONE:    o_result.status = ST_DONE;
            PH_TOOBIG:  o_result.status = ST_TOOBIG;
            PH_NOCOMMA: o_result.status = ST_NOCOMMA;
            default:    o_result.status = ST_BADCHAR;
        endcase

        o_result.header_length = (n_phase == PH_DONE) ? HDR_LEN_WIDTH'(accum_x) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= CFG_MAX_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            r_max_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_DIGITS;
            r_digit_count <= '0;
            r_accum       <= '0;
            r_remaining   <= '0;
            r_value_side  <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_accum       <= n_accum;
            r_remaining   <= n_remaining;
            r_value_side  <= n_value_side;
        end
    end

endmodule

// File: rtl/ndf_out_stage.sv
// ----------------------------------------------------------------------------
// Netstring header deframer result stage
// Registers each result and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module ndf_out_stage import ndf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ndf_ctrl   i_ctrl,
    input  t_ndf_result i_result,
    output logic        o_slot_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_ndf_result o_result
);

    logic        r_valid;
    t_ndf_result r_result;

    assign o_slot_free = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/netstring_header_deframer_unit.sv
// ----------------------------------------------------------------------------
// Netstring header deframer
// Parses a length-prefixed request header one byte per request.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_ready) carries one stream byte
// and a restart flag per request; restart clears the parser and makes that
// byte the first of a new header. The output channel (o_out_valid /
// i_out_ready) returns exactly one result per input request, in order.
// The length limit is written through i_cfg_wr_en / i_cfg_wr_data while the
// block is idle; it resets to 10239.
// Each byte passes through the input register, then the parse step into the
// result register. Throughput is one byte per cycle while the receiver does
// not stall, as the parse step updates its state when a byte moves on.
// Reset clears both stages and returns the parser to the length digits; no
// result is pending afterwards. When the receiver stalls, the result register
// holds its result, the input register fills behind it and then o_in_ready
// drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module netstring_header_deframer_unit import ndf_pkg::*; #(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]     i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [BYTE_WIDTH-1:0]    i_in_byte,
    input  logic                     i_restart,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [BYTE_WIDTH-1:0]    o_data_byte,
    output logic                     o_content_valid,
    output logic                     o_in_value,
    output logic                     o_end_of_string,
    output logic [STATUS_WIDTH-1:0]  o_status,
    output logic [HDR_LEN_WIDTH-1:0] o_header_length
);

    t_ndf_item   in_item;
    t_ndf_item   held_item;
    t_ndf_ctrl   ctrl;
    t_ndf_result step_result;
    t_ndf_result out_result;
    logic        slot_free;

    assign in_item.in_byte = i_in_byte;
    assign in_item.restart = i_restart;

    ndf_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (in_item),
        .i_slot_free (slot_free),
        .o_ctrl      (ctrl),
        .o_item      (held_item)
    );

    ndf_parse #(
        .MAX_DIGITS   (MAX_DIGITS),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctrl        (ctrl),
        .i_item        (held_item),
        .o_result      (step_result)
    );

    ndf_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_result    (step_result),
        .o_slot_free (slot_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (out_result)
    );

    assign o_data_byte     = out_result.data_byte;
    assign o_content_valid = out_result.content_valid;
    assign o_in_value      = out_result.in_value;
    assign o_end_of_string = out_result.end_of_string;
    assign o_status        = out_result.status;
    assign o_header_length = out_result.header_length;

endmodule

// File: rtl/ndf_checker.sv
// ----------------------------------------------------------------------------
// Netstring header deframer port checker
// Watches the result channel for consistency between its fields over time.
// ----------------------------------------------------------------------------
`include "netstring_header_deframer_unit_macros.svh"

module ndf_checker import ndf_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [BYTE_WIDTH-1:0]    o_data_byte,
    input logic                     o_content_valid,
    input logic                     o_in_value,
    input logic                     o_end_of_string,
    input logic [STATUS_WIDTH-1:0]  o_status,
    input logic [HDR_LEN_WIDTH-1:0] o_header_length
);

    // A stalled result must stay put until the receiver takes it.
    `NDF_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_data_byte) && $stable(o_status) && $stable(o_header_length), "result changed while stalled")

    // Content bytes only appear while the header is still being parsed.
    `NDF_ASSERT_SAME(a_content_busy, i_clk, i_rst_n, o_out_valid && o_content_valid, o_status == ST_BUSY, "content byte with a final status")

    // Outside the content the byte and its markers read as zero.
    `NDF_ASSERT_SAME(a_idle_fields, i_clk, i_rst_n, o_out_valid && !o_content_valid, o_data_byte == 8'h00 && !o_in_value && !o_end_of_string, "stray content fields")

    // The length is reported only with a complete status.
    `NDF_ASSERT_SAME(a_length_done, i_clk, i_rst_n, o_out_valid && o_status != ST_DONE, o_header_length == '0, "header length without completion")

endmodule

bind netstring_header_deframer_unit ndf_checker u_ndf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_data_byte     (o_data_byte),
    .o_content_valid (o_content_valid),
    .o_in_value      (o_in_value),
    .o_end_of_string (o_end_of_string),
    .o_status        (o_status),
    .o_header_length (o_header_length)
);
